>>> sv/chtl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chtl_pkg;

	// Key and result field widths.
	localparam int KEY_W = 30;
	localparam int CMP_W = 4;

	// Largest comparison count the result field can show.
	localparam int CMP_MAX = 15;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_HASH   = 6'b000100,
		ST_FETCH  = 6'b001000,
		ST_LOOKUP = 6'b010000,
		ST_CMP    = 6'b100000
	} state_t;

endpackage

`default_nettype wire

>>> sv/chained_hash_table_lookup_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Hash table of 30-bit keys with separate chaining into BUCKET_COUNT buckets of up to
// BUCKET_DEPTH keys each; the bucket is key modulo BUCKET_COUNT. A command beat is taken
// when start is high and busy is low; opcode 0 appends the key to its bucket, opcode 1
// searches the bucket from the front and stops at the first match. Every command gives
// exactly one result beat, marked by done for one cycle, and the receiver cannot stall it.
// After acceptance the block first forms the bucket index, the quotient by a multiplication
// with the reciprocal of the bucket count and then the remainder; it then reads the fill
// count and acts on it. An insert or a search of an empty bucket ends there; any other
// search walks the bucket, reading one entry a cycle from the key memory, until a match or
// the last stored key, up to BUCKET_DEPTH keys. After reset the block holds busy high
// while it sweeps the fill-count memory to zero. Comparison counts above 15 read as 15.
module chained_hash_table_lookup_unit #(
	parameter int BUCKET_COUNT = 1000,
	parameter int BUCKET_DEPTH = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       opcode,
	input  wire logic [chtl_pkg::KEY_W-1:0] key,
	output logic                            done,
	output logic                            found,
	output logic [chtl_pkg::CMP_W-1:0]      comparisons,
	output logic                            status
);

	import chtl_pkg::*;

	localparam int BW          = $clog2(BUCKET_COUNT);
	localparam int FW          = $clog2(BUCKET_DEPTH + 1);
	localparam int IW          = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int KEY_ENTRIES = BUCKET_COUNT * BUCKET_DEPTH;
	localparam int AW          = (KEY_ENTRIES > 1) ? $clog2(KEY_ENTRIES) : 1;
	localparam int MSH         = KEY_W + BW;
	localparam logic [KEY_W:0] RECIP = (KEY_W + 1)'(((64'd1 << MSH) +
	                                   64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT));

	state_t            state_q;
	logic [BW-1:0]     clr_q;
	logic              done_q;

	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic              hash_ph_q;
	logic [KEY_W-1:0]  quot_q;
	logic [BW-1:0]     rem_q;
	logic [AW-1:0]     base_q;
	logic [IW-1:0]     idx_q;
	logic [FW-1:0]     cmp_q;
	logic [FW-1:0]     fill_q;
	logic              found_q;
	logic [CMP_W-1:0]  cmp_out_q;
	logic              status_q;

	logic [KEY_W-1:0]  key_mem [KEY_ENTRIES];
	logic [FW-1:0]     fill_mem [BUCKET_COUNT];
	logic [KEY_W-1:0]  key_rd_q;
	logic [FW-1:0]     fill_rd_q;

	logic [2*KEY_W:0]  recip_prod;
	logic [KEY_W-1:0]  quot_next;
	logic [KEY_W-1:0]  rem_full;
	logic              bucket_full;
	logic              key_hit;
	logic [FW-1:0]     cmp_next;
	logic              cmp_last;
	logic [CMP_W-1:0]  cmp_sat;
	logic [IW-1:0]     idx_step;
	logic              key_we;
	logic [AW-1:0]     key_waddr;
	logic [AW-1:0]     key_raddr;
	logic              fill_we;
	logic [BW-1:0]     fill_waddr;
	logic [FW-1:0]     fill_wdata;

	// The reciprocal is rounded up with enough fraction bits that the quotient is exact
	// for every key of the field's width.
	assign recip_prod = (2 * KEY_W + 1)'(key_q) * (2 * KEY_W + 1)'(RECIP);
	assign quot_next  = KEY_W'(recip_prod >> MSH);
	assign rem_full   = key_q - KEY_W'(quot_q * KEY_W'(BUCKET_COUNT));

	assign bucket_full = (fill_rd_q >= FW'(BUCKET_DEPTH));
	assign key_hit     = (key_rd_q == key_q);
	assign cmp_next    = cmp_q + 1'b1;
	assign cmp_last    = (cmp_next == fill_q);
	assign cmp_sat     = (int'(cmp_next) > CMP_MAX) ? CMP_W'(CMP_MAX) : CMP_W'(cmp_next);

	// The read index stops at the last slot so that it never leaves the bucket.
	assign idx_step = (idx_q == IW'(BUCKET_DEPTH - 1)) ? idx_q : idx_q + 1'b1;

	assign key_we     = (state_q == ST_LOOKUP) && (op_q == OP_INSERT) && !bucket_full;
	assign key_waddr  = base_q + AW'(fill_rd_q);
	assign key_raddr  = base_q + AW'(idx_q);

	assign fill_we    = (state_q == ST_CLEAR) || key_we;
	assign fill_waddr = (state_q == ST_CLEAR) ? clr_q : rem_q;
	assign fill_wdata = (state_q == ST_CLEAR) ? '0 : fill_rd_q + 1'b1;

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= key_q;
		end
		key_rd_q <= key_mem[key_raddr];
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		fill_rd_q <= fill_mem[rem_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == BW'(BUCKET_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_ph_q) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					if (op_q == OP_INSERT || fill_rd_q == '0) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (key_hit || cmp_last) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q      <= opcode;
				key_q     <= key;
				hash_ph_q <= 1'b0;
			end
			ST_HASH: begin
				if (!hash_ph_q) begin
					quot_q    <= quot_next;
					hash_ph_q <= 1'b1;
				end else begin
					rem_q <= BW'(rem_full);
				end
			end
			ST_FETCH: begin
				base_q <= AW'(rem_q) * AW'(BUCKET_DEPTH);
				idx_q  <= '0;
				cmp_q  <= '0;
			end
			ST_LOOKUP: begin
				fill_q    <= fill_rd_q;
				idx_q     <= idx_step;
				found_q   <= 1'b0;
				cmp_out_q <= '0;
				if (op_q == OP_INSERT && bucket_full) begin
					status_q <= STATUS_FULL;
				end else begin
					status_q <= STATUS_OK;
				end
			end
			ST_CMP: begin
				cmp_q     <= cmp_next;
				idx_q     <= idx_step;
				found_q   <= key_hit;
				cmp_out_q <= cmp_sat;
				status_q  <= STATUS_OK;
			end
			default: begin
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign found       = found_q;
	assign comparisons = cmp_out_q;
	assign status      = status_q;

	// A result beat only follows a command that was being worked on.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_LOOKUP || $past(state_q) == ST_CMP))
		else $error("result beat without a command in progress");

	// A refused insert reports neither a hit nor any comparisons.
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_FULL) |-> (!found && comparisons == '0))
		else $error("refused insert carries search results");

	// A hit needs at least one comparison.
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (comparisons != '0))
		else $error("hit reported with no comparisons");

	// An accepted command makes the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting a command");

	// A bucket's fill count never runs past its depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP) |-> (fill_rd_q <= FW'(BUCKET_DEPTH)))
		else $error("bucket fill count beyond depth");

endmodule

`default_nettype wire
